// File: rtl/core/sphere_triangle_index_generator_top_assert.svh
// ----------------------------------------------------------------------------
// sphere triangle index generator assertion macros
// shared property shapes for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef SPHERE_TRIANGLE_INDEX_GENERATOR_TOP_ASSERT_SVH
`define SPHERE_TRIANGLE_INDEX_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define STIG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define STIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/stig_pkg.sv
// ----------------------------------------------------------------------------
// stig_pkg
// types, constants and helpers shared by the triangle index generator core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stig_pkg;

    // largest supported rows per hemisphere
    localparam int unsigned MaxRows = 64;

    localparam int unsigned RowW  = 7;
    localparam int unsigned RingW = 8;
    localparam int unsigned VtxW  = 15;
    localparam int unsigned CntW  = 16;
    localparam int unsigned ColW  = 10;
    localparam int unsigned SizeW = 9;

    localparam logic [RowW-1:0] RowCountReset = 7'd8;

    // triangle kind inside one quadrant strip
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2
    } t_phase;

    // mesh walk position
    typedef struct packed {
        logic [RingW-1:0] ring_row;
        logic [1:0]       quadrant;
        logic [5:0]       column_step;
        t_phase           phase;
        logic [CntW-1:0]  tri_count;
        logic [VtxW-1:0]  cur_base;
        logic [VtxW-1:0]  prev_base;
        logic             finished;
    } t_pos;

    // ring facts derived from the current row
    typedef struct packed {
        logic [6:0]       lim;
        logic [SizeW-1:0] cs;
    } t_ring;

    localparam t_pos PosReset = '{
        ring_row:    8'd1,
        quadrant:    2'd0,
        column_step: 6'd0,
        phase:       PH_FIRST,
        tri_count:   16'd0,
        cur_base:    15'd2,
        prev_base:   15'd1,
        finished:    1'b0
    };

    // base plus column, column wrapped once by the ring size; pole rings give base
    function automatic logic [VtxW-1:0] f_vertex(input logic [VtxW-1:0]  base,
                                                 input logic [SizeW-1:0] size,
                                                 input logic [ColW-1:0]  col);
        logic [ColW-1:0] wcol;
        if (size == '0) begin
            wcol = '0;
        end else if (col >= ColW'(size)) begin
            wcol = col - ColW'(size);
        end else begin
            wcol = col;
        end
        return base + VtxW'(wcol);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/stig_vertex.sv
// ----------------------------------------------------------------------------
// stig_vertex
// ring geometry and vertex triplet for the current mesh position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stig_vertex
    import stig_pkg::*;
(
    input  t_pos            i_pos,
    input  logic [RowW-1:0] i_rows,
    output t_ring           o_ring,
    output logic [VtxW-1:0] o_vtx_a,
    output logic [VtxW-1:0] o_vtx_b,
    output logic [VtxW-1:0] o_vtx_c
);

    logic [RingW-1:0] two_n;
    logic [RingW-1:0] low_k;
    logic             upper;
    logic [6:0]       k;
    logic [6:0]       pk;
    logic [SizeW-1:0] cs;
    logic [SizeW-1:0] ps;
    logic [ColW-1:0]  q10;
    logic [ColW-1:0]  j0;
    logic [ColW-1:0]  j2;
    logic             cur_a, cur_b, cur_c;
    logic [ColW-1:0]  col_a, col_b, col_c;

    // ring sizes, strip width and quadrant column offset
    always_comb begin
        two_n = {i_rows, 1'b0};
        low_k = two_n - i_pos.ring_row;
        upper = (i_pos.ring_row <= RingW'(i_rows));
        k     = upper ? i_pos.ring_row[6:0] : low_k[6:0];
        pk    = upper ? (k - 7'd1) : (k + 7'd1);
        cs    = {k, 2'b00};
        ps    = {pk, 2'b00};
        q10   = ColW'(i_pos.quadrant);
        j0    = q10 * ColW'(k);
        j2    = j0 + ColW'(i_pos.column_step);
    end

    assign o_ring.lim = upper ? pk : k;
    assign o_ring.cs  = cs;

    // pick ring and column of each corner
    always_comb begin
        if (upper) begin
            case (i_pos.phase)
                PH_FIRST: begin
                    cur_a = 1'b0; col_a = j0 - q10;
                    cur_b = 1'b1; col_b = j0;
                    cur_c = 1'b1; col_c = j0 + 10'd1;
                end
                PH_LOW: begin
                    cur_a = 1'b1; col_a = j2;
                    cur_b = 1'b0; col_b = j2 - q10;
                    cur_c = 1'b0; col_c = j2 - 10'd1 - q10;
                end
                default: begin
                    cur_a = 1'b0; col_a = j2 - q10;
                    cur_b = 1'b1; col_b = j2;
                    cur_c = 1'b1; col_c = j2 + 10'd1;
                end
            endcase
        end else begin
            case (i_pos.phase)
                PH_FIRST: begin
                    cur_a = 1'b1; col_a = j0;
                    cur_b = 1'b0; col_b = j0 + 10'd1 + q10;
                    cur_c = 1'b0; col_c = j0 + q10;
                end
                PH_LOW: begin
                    cur_a = 1'b1; col_a = j2;
                    cur_b = 1'b0; col_b = j2 + q10;
                    cur_c = 1'b1; col_c = j2 - 10'd1;
                end
                default: begin
                    cur_a = 1'b1; col_a = j2;
                    cur_b = 1'b0; col_b = j2 + 10'd1 + q10;
                    cur_c = 1'b0; col_c = j2 + q10;
                end
            endcase
        end
    end

    // wrapped vertex indices
    assign o_vtx_a = f_vertex(cur_a ? i_pos.cur_base : i_pos.prev_base, cur_a ? cs : ps, col_a);
    assign o_vtx_b = f_vertex(cur_b ? i_pos.cur_base : i_pos.prev_base, cur_b ? cs : ps, col_b);
    assign o_vtx_c = f_vertex(cur_c ? i_pos.cur_base : i_pos.prev_base, cur_c ? cs : ps, col_c);

endmodule

`default_nettype wire

// File: rtl/core/stig_seq.sv
// ----------------------------------------------------------------------------
// stig_seq
// mesh walk position register and its advance logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sphere_triangle_index_generator_top_assert.svh"

module stig_seq
    import stig_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_write,
    input  logic            i_advance,
    input  logic            i_restart,
    input  logic [RowW-1:0] i_rows,
    input  logic [CntW-1:0] i_total,
    input  t_ring           i_ring,
    output t_pos            o_pos,
    output logic            o_done,
    output logic [CntW-1:0] o_count,
    output logic            o_last
);

    t_pos            r_pos;
    t_pos            n_pos;
    t_pos            eff;
    logic [CntW-1:0] count_new;
    logic            next_quad;

    // position seen by this request, restart applied first
    always_comb begin
        eff       = i_restart ? PosReset : r_pos;
        o_done    = eff.finished || (eff.ring_row == '0) ||
                    (eff.ring_row > {i_rows, 1'b0});
        count_new = eff.tri_count + 16'd1;
    end

    assign o_pos   = eff;
    assign o_count = count_new;
    assign o_last  = (count_new == i_total);

    // step to the next triangle
    always_comb begin
        n_pos     = eff;
        next_quad = 1'b0;
        if (o_done) begin
            n_pos.finished = 1'b1;
        end else begin
            n_pos.tri_count = count_new;
            case (eff.phase)
                PH_FIRST: begin
                    if (i_ring.lim >= 7'd1) begin
                        n_pos.column_step = 6'd1;
                        n_pos.phase       = PH_LOW;
                    end else begin
                        next_quad = 1'b1;
                    end
                end
                PH_LOW: begin
                    n_pos.phase = PH_HIGH;
                end
                default: begin
                    if (7'(eff.column_step) < i_ring.lim) begin
                        n_pos.column_step = eff.column_step + 6'd1;
                        n_pos.phase       = PH_LOW;
                    end else begin
                        next_quad = 1'b1;
                    end
                end
            endcase
            if (next_quad) begin
                n_pos.column_step = 6'd0;
                n_pos.phase       = PH_FIRST;
                n_pos.quadrant    = eff.quadrant + 2'd1;
                if (eff.quadrant == 2'd3) begin
                    n_pos.prev_base = eff.cur_base;
                    n_pos.cur_base  = eff.cur_base + VtxW'(i_ring.cs);
                    n_pos.ring_row  = eff.ring_row + 8'd1;
                end
            end
            n_pos.finished = (count_new >= i_total);
        end
    end

    // position register, config write returns to the first triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_write) begin
            r_pos <= PosReset;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    `STIG_ASSERT_IMPL(a_count_below_total, i_clk, i_rst_n, !r_pos.finished, r_pos.tri_count < i_total, "unfinished walk has reached the triangle total")
    `STIG_ASSERT_NEXT(a_last_finishes, i_clk, i_rst_n, i_advance && !i_cfg_write && !o_done && o_last, r_pos.finished, "final triangle did not close the walk")
    `STIG_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, i_cfg_write, r_pos == PosReset, "config write did not return to the first triangle")

endmodule

`default_nettype wire

// File: rtl/core/sphere_triangle_index_generator_top.sv
// ----------------------------------------------------------------------------
// sphere_triangle_index_generator_top
// octahedral sphere mesh triangle index stream
// ----------------------------------------------------------------------------
// usage
//   cfg channel: i_cfg_valid/o_cfg_ready with i_cfg_data = rows per hemisphere
//   (0 acts as 1, above 64 acts as 64); a write also restarts the mesh walk.
//   slave stream: each request carries a restart bit in tdata bit 0; restart
//   begins again at triangle 1, otherwise the next triangle is produced.
//   master stream: one result per request with the three 1-based vertex
//   indices and the triangle number in tdata, tlast on the final triangle,
//   tuser high (and all data zero) once the mesh is exhausted.
// result timing and throughput
//   a result is valid in the cycle after its request is taken; one request per
//   cycle is sustained while i_m_axis_tready stays high, set by the single result
//   register behind the position and vertex logic.
// reset
//   rows per hemisphere returns to 8 and the walk to triangle 1; no clearing
//   pass, requests are taken the cycle reset is released.
// stall
//   while a result waits on i_m_axis_tready, o_s_axis_tready stays low; it
//   rises in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sphere_triangle_index_generator_top_assert.svh"

module sphere_triangle_index_generator_top
    import stig_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data,      // row_count
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [0] restart, [7:1] zero
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,  // [14:0] vertex_first, [29:15] vertex_second,
                                              // [44:30] vertex_third,
                                              // [60:45] triangle_number, [63:61] zero
    output logic             o_m_axis_tlast,  // last
    output logic [0:0]       o_m_axis_tuser   // [0] done_res
);

    logic [RowW-1:0] r_row_count;
    logic [RowW-1:0] rows;
    logic [12:0]     rows_sq;
    logic [CntW-1:0] total;
    logic            cfg_write;
    logic            in_accept;

    t_pos            pos;
    t_ring           ring;
    logic            done;
    logic [CntW-1:0] count;
    logic            last;
    logic [VtxW-1:0] vtx_a, vtx_b, vtx_c;

    logic            r_out_valid;
    logic [63:0]     r_out_data;
    logic            r_out_last;
    logic            r_out_done;
    logic [63:0]     n_out_data;

    // handshakes
    assign o_cfg_ready     = i_rst_n;
    assign cfg_write       = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = i_rst_n && (!r_out_valid || i_m_axis_tready);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RowCountReset;
        end else if (cfg_write) begin
            r_row_count <= i_cfg_data;
        end
    end

    // effective rows and triangle total 8*n*n
    always_comb begin
        if (r_row_count == '0) begin
            rows = 7'd1;
        end else if (r_row_count > RowW'(MaxRows)) begin
            rows = RowW'(MaxRows);
        end else begin
            rows = r_row_count;
        end
        rows_sq = 13'(rows) * 13'(rows);
        total   = {rows_sq, 3'b000};
    end

    stig_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (cfg_write),
        .i_advance   (in_accept),
        .i_restart   (i_s_axis_tdata[0]),
        .i_rows      (rows),
        .i_total     (total),
        .i_ring      (ring),
        .o_pos       (pos),
        .o_done      (done),
        .o_count     (count),
        .o_last      (last)
    );

    stig_vertex u_vertex (
        .i_pos   (pos),
        .i_rows  (rows),
        .o_ring  (ring),
        .o_vtx_a (vtx_a),
        .o_vtx_b (vtx_b),
        .o_vtx_c (vtx_c)
    );

    // result payload, zero once exhausted
    assign n_out_data = done ? 64'd0 : {3'b000, count, vtx_c, vtx_b, vtx_a};

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
            r_out_last <= !done && last;
            r_out_done <= done;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tlast    = r_out_last;
    assign o_m_axis_tuser[0] = r_out_done;

    `STIG_ASSERT_IMPL(a_done_is_empty, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata == 64'd0) && !o_m_axis_tlast, "done result carries triangle data")
    `STIG_ASSERT_IMPL(a_valid_from_request, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(in_accept), "result appeared without a taken request")

endmodule

`default_nettype wire

// File: tb/sphere_triangle_index_generator_top_tb.sv
// ----------------------------------------------------------------------------
// sphere_triangle_index_generator_top_tb
// drives restart/advance requests and row-count writes into the triangle
// index generator, predicts every vertex triplet in the bench and compares
// each result on the master stream with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_triangle_index_generator_top_tb;
    import stig_pkg::*;

    localparam int ClkHalf     = 4;
    localparam int DrainCycles = 4;
    localparam int QuietLimit  = 4000;

    // one predicted result
    typedef struct packed {
        logic [VtxW-1:0] v_first;
        logic [VtxW-1:0] v_second;
        logic [VtxW-1:0] v_third;
        logic [CntW-1:0] number;
        logic            last;
        logic            done;
    } t_mesh_triangle;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [0] restart, [7:1] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [14:0] vertex_first, [29:15] vertex_second,
                                   // [44:30] vertex_third, [60:45] triangle_number
    logic        o_m_axis_tlast;   // last
    logic [0:0]  o_m_axis_tuser;   // [0] done_res

    // predictor copy of the register and the mesh walk
    logic [RowW-1:0]  mesh_rows;
    logic [RingW-1:0] walk_ring;
    logic [1:0]       walk_quad;
    logic [7:0]       walk_col;
    t_phase           walk_phase;
    logic [CntW-1:0]  walk_count;
    logic [VtxW-1:0]  base_cur;
    logic [VtxW-1:0]  base_prev;
    logic             walk_done;

    t_mesh_triangle expected_triangles[$];
    int error_count;
    int sender_idle_pct;
    int sink_idle_pct;
    int quiet_cycles;

    sphere_triangle_index_generator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    always #(ClkHalf) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int unsigned effective_rows();
        if (mesh_rows == 0) return 1;
        if (mesh_rows > MaxRows) return MaxRows;
        return mesh_rows;
    endfunction

    // vertices in ring r, poles have none
    function automatic int unsigned ring_span(input int unsigned r, input int unsigned n);
        if (r == 0 || r >= 2 * n) return 0;
        if (r <= n) return 4 * r;
        return 4 * (2 * n - r);
    endfunction

    function automatic logic [VtxW-1:0] vertex_of(input int unsigned base,
                                                  input int unsigned size,
                                                  input int unsigned col);
        if (size == 0) return VtxW'(base);
        return VtxW'(base + col % size);
    endfunction

    task automatic restart_walk();
        walk_ring  = 8'd1;
        walk_quad  = 2'd0;
        walk_col   = 8'd0;
        walk_phase = PH_FIRST;
        walk_count = '0;
        base_cur   = 15'd2;
        base_prev  = 15'd1;
        walk_done  = 1'b0;
    endtask

    // work out the triangle for one accepted request and queue it
    task automatic predict_triangle(input logic restart);
        int unsigned n, total, r, q, s, cb, pb, cs, ps, lim, j0, j2;
        logic [VtxW-1:0] a, b, c;
        logic upper, next_quad;
        t_mesh_triangle res;
        n = effective_rows();
        total = 8 * n * n;
        res = '0;
        if (restart) restart_walk();

        // mesh exhausted
        if (walk_done || walk_ring < 1 || walk_ring > 2 * n) begin
            walk_done = 1'b1;
            res.done = 1'b1;
            expected_triangles.push_back(res);
            return;
        end

        r = walk_ring;
        q = walk_quad;
        s = walk_col;
        cb = base_cur;
        pb = base_prev;
        cs = ring_span(r, n);
        ps = ring_span(r - 1, n);
        upper = (r <= n);
        lim = upper ? r - 1 : 2 * n - r;
        j0 = q * (upper ? r : 2 * n - r);
        j2 = j0 + s;

        // upper hemisphere strips point up, lower ones down
        if (upper) begin
            case (walk_phase)
                PH_FIRST: begin
                    a = vertex_of(pb, ps, j0 - q);
                    b = vertex_of(cb, cs, j0);
                    c = vertex_of(cb, cs, j0 + 1);
                end
                PH_LOW: begin
                    a = vertex_of(cb, cs, j2);
                    b = vertex_of(pb, ps, j2 - q);
                    c = vertex_of(pb, ps, j2 - 1 - q);
                end
                default: begin
                    a = vertex_of(pb, ps, j2 - q);
                    b = vertex_of(cb, cs, j2);
                    c = vertex_of(cb, cs, j2 + 1);
                end
            endcase
        end else begin
            case (walk_phase)
                PH_FIRST: begin
                    a = vertex_of(cb, cs, j0);
                    b = vertex_of(pb, ps, j0 + 1 + q);
                    c = vertex_of(pb, ps, j0 + q);
                end
                PH_LOW: begin
                    a = vertex_of(cb, cs, j2);
                    b = vertex_of(pb, ps, j2 + q);
                    c = vertex_of(cb, cs, j2 - 1);
                end
                default: begin
                    a = vertex_of(cb, cs, j2);
                    b = vertex_of(pb, ps, j2 + 1 + q);
                    c = vertex_of(pb, ps, j2 + q);
                end
            endcase
        end

        walk_count = walk_count + 1'b1;
        res.v_first  = a;
        res.v_second = b;
        res.v_third  = c;
        res.number   = walk_count;
        res.last     = (walk_count == total);
        expected_triangles.push_back(res);

        // step to the next triangle of the strip, quadrant or ring
        next_quad = 1'b0;
        case (walk_phase)
            PH_FIRST: begin
                if (lim >= 1) begin
                    walk_col = 8'd1;
                    walk_phase = PH_LOW;
                end else begin
                    next_quad = 1'b1;
                end
            end
            PH_LOW: walk_phase = PH_HIGH;
            default: begin
                if (s < lim) begin
                    walk_col = walk_col + 1'b1;
                    walk_phase = PH_LOW;
                end else begin
                    next_quad = 1'b1;
                end
            end
        endcase
        if (next_quad) begin
            walk_col = 8'd0;
            walk_phase = PH_FIRST;
            if (q == 3) begin
                walk_quad = 2'd0;
                base_prev = base_cur;
                base_cur = VtxW'(base_cur + cs);
                walk_ring = RingW'(r + 1);
            end else begin
                walk_quad = walk_quad + 1'b1;
            end
        end
        if (walk_count >= total) walk_done = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one request on the slave stream, random gaps before it
    task automatic send_request(input logic restart);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, restart};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_triangle(restart);
    endtask

    // stop sending until every queued result has come back
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (expected_triangles.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // row-count write, only with the block idle
    task automatic write_rows(input logic [RowW-1:0] rows);
        hold_until_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = rows;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mesh_rows = rows;
        restart_walk();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // random receiver stalls
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mesh_triangle want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_triangles.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                want = expected_triangles.pop_front();
                check_field("vertex_first", want.v_first, o_m_axis_tdata[14:0]);
                check_field("vertex_second", want.v_second, o_m_axis_tdata[29:15]);
                check_field("vertex_third", want.v_third, o_m_axis_tdata[44:30]);
                check_field("triangle_number", want.number, o_m_axis_tdata[60:45]);
                check_field("tdata padding", 0, o_m_axis_tdata[63:61]);
                check_field("last", want.last, o_m_axis_tlast);
                check_field("done_res", want.done, o_m_axis_tuser[0]);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // eight rows after reset, restart mid-walk
    task automatic test_reset_default();
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // zero acts as one row: full mesh, done answers, then restart
    task automatic test_single_row_and_done();
        write_rows(7'd0);
        repeat (10) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // counts above the maximum clamp, a write restarts the walk
    task automatic test_row_clamp();
        write_rows(7'd127);
        repeat (2) send_request(1'b0);
        write_rows(7'd65);
        repeat (2) send_request(1'b0);
    endtask

    // random row counts, mostly small meshes walked past their end
    task automatic test_random_mesh(input int item_goal, input int sender_pct,
                                    input int sink_pct);
        int sent, seg_len, pick;
        int unsigned n;
        logic [RowW-1:0] rows;
        sender_idle_pct = sender_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) rows = RowW'($urandom_range(1, 6));
            else if (pick < 85) rows = RowW'($urandom_range(7, 64));
            else if (pick < 92) rows = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd64;
            else rows = RowW'($urandom_range(65, 127));
            write_rows(rows);
            n = effective_rows();
            if (n <= 6) seg_len = 8 * n * n + $urandom_range(0, 5);
            else seg_len = $urandom_range(16, 96);
            for (int k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 39) == 0) hold_until_drained();
                send_request($urandom_range(0, 63) == 0);
            end
            sent += seg_len;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        error_count = 0;
        sender_idle_pct = 13;
        sink_idle_pct = 88;
        quiet_cycles = 0;
        mesh_rows = RowCountReset;
        restart_walk();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_default();
        test_single_row_and_done();
        test_row_clamp();
        test_random_mesh(480, 13, 88);
        test_random_mesh(480, 88, 13);
        test_random_mesh(480, 0, 0);

        hold_until_drained();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
